FILE: sv/tmdm_pkg.sv
// shared types and constants for the trimmed mean unit
`timescale 1ns / 1ps

package tmdm_pkg;

    // field and accumulator widths
    localparam int SAMPLE_W = 32;
    localparam int SIZE_W   = 8;
    localparam int SUM_W    = 40;

    // divider iterates one quotient bit per cycle over the whole sum
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // group size handling
    localparam logic [SIZE_W-1:0] GROUP_RESET = SIZE_W'(5);
    localparam logic [SIZE_W-1:0] MIN_GROUP   = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] TRIM_COUNT  = SIZE_W'(2);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIM_LO,
        ST_TRIM_HI,
        ST_START,
        ST_DIVIDE,
        ST_DELIVER
    } t_state;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: sv/tmdm_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tmdm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tmdm_pkg::SUM_W-1:0]    i_dividend,
    input  logic [tmdm_pkg::SIZE_W-1:0]   i_divisor,
    output tmdm_pkg::t_div_stat           o_stat,
    output logic [tmdm_pkg::SAMPLE_W-1:0] o_quotient
);
    import tmdm_pkg::*;

    logic [SUM_W-1:0]     r_work;
    logic [SUM_W-1:0]     n_work;
    logic [SIZE_W-1:0]    r_rem;
    logic [SIZE_W-1:0]    n_rem;
    logic [SIZE_W-1:0]    r_divisor;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [SIZE_W:0]      w_shift;
    logic [SIZE_W:0]      w_diff;
    logic                 w_ge;

    // one restoring step: bring down the next dividend bit, try to subtract
    always_comb begin
        w_shift = {r_rem, r_work[SUM_W-1]};
        w_ge    = (w_shift >= {1'b0, r_divisor});
        w_diff  = w_shift - {1'b0, r_divisor};
        n_rem   = w_ge ? w_diff[SIZE_W-1:0] : w_shift[SIZE_W-1:0];
        n_work  = {r_work[SUM_W-2:0], w_ge};
    end

    // control: busy while the steps run, done pulse after the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath: remainder and the dividend/quotient shift word
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_work[SAMPLE_W-1:0];

`ifndef NO_ASSERTIONS
    // a start never lands on a division in flight
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    // done comes right after the final step
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finished run");

    // a divisor of zero never enters a run
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_divisor != '0)
        else $error("divider running with zero divisor");
`endif

endmodule

FILE: sv/trimmed_mean_drop_min_max_unit.sv
// top level: group accumulator, trim sequencer and output register
`timescale 1ns / 1ps

// Trimmed mean unit. Takes unsigned 32-bit samples one beat at a time and groups
// them by the group_size register (reset value 5). At the end of each group it
// delivers one beat holding (sum - min - max) / (group_size - 2), truncated. A
// sample that does not close a group is accepted back to back. The closing
// sample starts a trim and divide pass (subtract the minimum, subtract the
// maximum, start, 40 bit-serial divider steps, the done pulse and a hand-off),
// during which o_stall stays high; the hand-off waits longer while i_stall holds
// an earlier result in the output register. With group_size below 3 every
// sample yields an average of 0 on the next cycle, and the next sample waits
// until that beat is taken. A pending register write holds o_stall high.
// Writing group_size restarts the current group; write it only while the unit
// is idle.
module trimmed_mean_drop_min_max_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tmdm_pkg::SAMPLE_W-1:0] i_sample,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tmdm_pkg::SAMPLE_W-1:0] o_average,
    // group size register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tmdm_pkg::SIZE_W-1:0]   i_cfg_data
);
    import tmdm_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [SIZE_W-1:0]    r_group_size;
    logic [SIZE_W-1:0]    r_count;
    logic [SIZE_W-1:0]    w_count_inc;
    logic [SUM_W-1:0]     r_sum;
    logic [SAMPLE_W-1:0]  r_min;
    logic [SAMPLE_W-1:0]  r_max;
    logic                 r_out_valid;
    logic [SAMPLE_W-1:0]  r_average;
    logic                 w_accept;
    logic                 w_cfg_wr;
    logic                 w_small;
    logic                 w_last;
    logic                 w_slot_free;
    logic                 w_div_start;
    logic                 w_deliver;
    logic                 w_clear;
    t_div_stat            w_div_stat;
    logic [SAMPLE_W-1:0]  w_quotient;

    // handshakes and group bookkeeping
    always_comb begin
        w_small     = (r_group_size < MIN_GROUP);
        w_cfg_wr    = i_cfg_valid && o_cfg_ready;
        w_accept    = i_valid && !o_stall;
        w_count_inc = r_count + 1'b1;
        w_last      = (w_count_inc == r_group_size);
        w_slot_free = !r_out_valid || !i_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && !w_small && w_last) begin
                    n_state = ST_TRIM_LO;
                end
            end
            ST_TRIM_LO: n_state = ST_TRIM_HI;
            ST_TRIM_HI: n_state = ST_START;
            ST_START:   n_state = ST_DIVIDE;
            ST_DIVIDE: begin
                if (w_div_stat.done) begin
                    n_state = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall     = 1'b1;
        o_cfg_ready = 1'b0;
        w_div_start = 1'b0;
        w_deliver   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // a register write takes the cycle, samples wait behind it
                o_stall     = (r_out_valid && w_small) || i_cfg_valid;
                o_cfg_ready = 1'b1;
            end
            ST_START:   w_div_start = 1'b1;
            ST_DELIVER: w_deliver   = w_slot_free;
            default: begin
                o_stall = 1'b1;
            end
        endcase
        w_clear = w_cfg_wr || w_deliver;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // group size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GROUP_RESET;
        end else if (w_cfg_wr) begin
            r_group_size <= i_cfg_data;
        end
    end

    // accumulators: sum, extremes and count, then trimmed in place
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else if (w_accept && !w_small) begin
            r_count <= w_count_inc;
            r_sum   <= r_sum + SUM_W'(i_sample);
            if (i_sample < r_min) begin
                r_min <= i_sample;
            end
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
        end else if (r_state == ST_TRIM_LO) begin
            r_sum <= r_sum - SUM_W'(r_min);
        end else if (r_state == ST_TRIM_HI) begin
            r_sum <= r_sum - SUM_W'(r_max);
        end
    end

    // divider for the trimmed sum
    tmdm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_group_size - TRIM_COUNT),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_small) begin
            r_out_valid <= 1'b1;
        end else if (w_deliver) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_small) begin
            r_average <= '0;
        end else if (w_deliver) begin
            r_average <= w_quotient;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_average = r_average;

`ifndef NO_ASSERTIONS
    // the divider only reports back while the sequencer waits for it
    a_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> r_state == ST_DIVIDE)
        else $error("divider done outside the divide state");

    // a started division is running on the next cycle
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_START |=> w_div_stat.busy)
        else $error("divider did not start");

    // in idle the partial group is always short of a full group
    a_count_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !w_small) |-> r_count < r_group_size)
        else $error("group count reached group size in idle");

    // a pending result is never overwritten by a new one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_deliver || (w_accept && w_small)) |-> w_slot_free)
        else $error("result register overwritten");
`endif

endmodule
